/* sv/escaped_frame_receiver_crc8_core_defines.svh */
// Assertion macros for the RTL; only efr_seq includes them.
`ifndef ESCAPED_FRAME_RECEIVER_CRC8_CORE_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_CRC8_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define EFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define EFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define EFR_ASSERT(lbl, clk, rst_n, prop, msg)

`define EFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* sv/efr_pkg.sv */
package efr_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  localparam logic [7:0] HDR_BYTE = 8'hAC;
  localparam logic [7:0] FTR_BYTE = 8'hAD;
  localparam logic [7:0] ESC_BYTE = 8'hAE;
  localparam logic [7:0] ESC_FLIP = 8'h80;
  localparam logic [7:0] CRC_POLY = 8'h8C;   // 0x31 reflected

  localparam logic [5:0]  MAX_LENGTH_RST = 6'd35;
  localparam logic [15:0] ERR_CNT_MAX    = 16'hFFFF;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_CRC      = 2'd2;
  localparam logic [1:0] ERR_OVERLONG = 2'd3;

  // CRC-8/Maxim, one byte, bit-serial form unrolled over eight steps
  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/efr_if.sv */
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_byte;
  logic [5:0]  byte_index;
  logic        last_byte;
  logic [1:0]  error_code;
  logic [15:0] error_total;

  modport source (output valid, output msg_byte, output byte_index, output last_byte,
                  output error_code, output error_total, input ready);
  modport sink   (input valid, input msg_byte, input byte_index, input last_byte,
                  input error_code, input error_total, output ready);
endinterface

interface efr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink   (input valid, input max_length, output ready);
endinterface

/* sv/efr_store.sv */
module efr_store #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned AW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/efr_seq.sv */
`include "escaped_frame_receiver_crc8_core_defines.svh"

module efr_seq #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned AW = $clog2(BUFFER_DEPTH),
  parameter int unsigned LW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  efr_in_if.sink        rx_i,
  efr_out_if.source     msg_o,
  input  logic [5:0]    max_len_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [7:0]    mem_rdata_i
);
  import efr_pkg::*;

  typedef enum logic {ST_RX, ST_EMIT} state_e;

  state_e        state_q;
  logic          in_frame_q;
  logic          esc_q;
  logic [LW-1:0] len_q;
  logic [7:0]    crc_q;
  logic [15:0]   err_cnt_q;
  logic [AW-1:0] rd_idx_q;
  logic [AW-1:0] rd_k_q;
  logic          rd_pend_q;
  logic          rd_last_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [5:0]  out_idx_q;
  logic        out_last_q;
  logic [1:0]  out_code_q;
  logic [15:0] out_total_q;

  logic        in_hs;
  logic        out_free;
  logic [7:0]  bd;
  logic        is_ftr;
  logic        is_esc_start;
  logic        full;
  logic        over;
  logic        store_hs;
  logic        issue;
  logic        err_raise;
  logic [1:0]  err_code;
  logic [15:0] err_cnt_d;
  logic [LW-1:0] len_d;

  assign out_free    = !out_valid_q || msg_o.ready;
  assign rx_i.ready  = (state_q == ST_RX) && out_free;
  assign in_hs       = rx_i.valid && rx_i.ready;

  assign bd           = esc_q ? (rx_i.rx_byte ^ ESC_FLIP) : rx_i.rx_byte;
  assign is_ftr       = rx_i.rx_byte == FTR_BYTE;
  assign is_esc_start = !esc_q && (rx_i.rx_byte == ESC_BYTE);
  assign full         = len_q == LW'(BUFFER_DEPTH);
  assign len_d        = len_q + LW'(1);
  assign over         = (9'(len_q) + 9'd1) > 9'(max_len_i);
  assign store_hs     = in_hs && in_frame_q && !is_ftr && !is_esc_start;

  assign mem_we_o    = store_hs && !full;
  assign mem_waddr_o = len_q[AW-1:0];
  assign mem_wdata_o = bd;

  assign issue       = (state_q == ST_EMIT) && !rd_pend_q && out_free;
  assign mem_re_o    = issue;
  assign mem_raddr_o = rd_idx_q;

  assign err_cnt_d = (err_cnt_q == ERR_CNT_MAX) ? err_cnt_q : err_cnt_q + 16'd1;

  // a frame with its CRC byte appended leaves a zero remainder, so the check is crc == 0
  always_comb begin
    err_raise = 1'b0;
    err_code  = ERR_NONE;
    if (in_hs && in_frame_q) begin
      if (is_ftr) begin
        if (len_q == '0) begin
          err_raise = 1'b1;
          err_code  = ERR_EMPTY;
        end else if (crc_q != 8'h00) begin
          err_raise = 1'b1;
          err_code  = ERR_CRC;
        end
      end else if (store_hs && (full || over)) begin
        err_raise = 1'b1;
        err_code  = ERR_OVERLONG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RX;
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      len_q       <= '0;
      crc_q       <= 8'h00;
      err_cnt_q   <= 16'd0;
      rd_idx_q    <= '0;
      rd_k_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'h00;
      out_idx_q   <= 6'd0;
      out_last_q  <= 1'b0;
      out_code_q  <= ERR_NONE;
      out_total_q <= 16'd0;
    end else begin
      if (out_valid_q && msg_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_RX: begin
          if (in_hs) begin
            if (!in_frame_q) begin
              in_frame_q <= rx_i.rx_byte == HDR_BYTE;
              len_q      <= '0;
              esc_q      <= 1'b0;
              crc_q      <= 8'h00;
            end else if (is_ftr) begin
              in_frame_q <= 1'b0;
              if (!err_raise) begin
                state_q  <= ST_EMIT;
                rd_idx_q <= '0;
              end
            end else if (is_esc_start) begin
              esc_q <= 1'b1;
            end else begin
              esc_q <= 1'b0;
              if (full) begin
                in_frame_q <= 1'b0;
              end else begin
                len_q <= len_d;
                crc_q <= crc8_add(crc_q, bd);
                if (over) begin
                  in_frame_q <= 1'b0;
                end
              end
            end
          end
          if (err_raise) begin
            err_cnt_q   <= err_cnt_d;
            out_valid_q <= 1'b1;
            out_byte_q  <= 8'h00;
            out_idx_q   <= 6'd0;
            out_last_q  <= 1'b1;
            out_code_q  <= err_code;
            out_total_q <= err_cnt_d;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            rd_pend_q <= 1'b1;
            rd_k_q    <= rd_idx_q;
            rd_last_q <= (LW'(rd_idx_q) + LW'(1)) == len_q;
            rd_idx_q  <= rd_idx_q + AW'(1);
          end
          if (rd_pend_q) begin
            rd_pend_q   <= 1'b0;
            out_valid_q <= 1'b1;
            out_byte_q  <= mem_rdata_i;
            out_idx_q   <= 6'(rd_k_q);
            out_last_q  <= rd_last_q;
            out_code_q  <= ERR_NONE;
            out_total_q <= err_cnt_q;
            if (rd_last_q) begin
              state_q <= ST_RX;
            end
          end
        end
        default: begin
          state_q <= ST_RX;
        end
      endcase
    end
  end

  assign msg_o.valid       = out_valid_q;
  assign msg_o.msg_byte    = out_byte_q;
  assign msg_o.byte_index  = out_idx_q;
  assign msg_o.last_byte   = out_last_q;
  assign msg_o.error_code  = out_code_q;
  assign msg_o.error_total = out_total_q;

  `EFR_ASSERT(a_rd_lands, clk_i, rst_ni, rd_pend_q |=> out_valid_q, "read data not loaded")
  `EFR_ASSERT(a_rd_in_emit, clk_i, rst_ni, rd_pend_q |-> state_q == ST_EMIT, "read outside emit")
  `EFR_ASSERT(a_cnt_mono, clk_i, rst_ni, 1'b1 |=> err_cnt_q >= $past(err_cnt_q), "error count fell")
  `EFR_ASSERT_NEVER(a_len_range, clk_i, rst_ni, len_q > LW'(BUFFER_DEPTH), "length past depth")
  `EFR_ASSERT_NEVER(a_wr_in_emit, clk_i, rst_ni, mem_we_o && state_q == ST_EMIT, "write during emit")

endmodule

/* sv/escaped_frame_receiver_crc8_core.sv */
// An error result is registered and appears in the cycle after the closing or failing item.
// A good frame is emitted from the frame store after the footer, each byte taking one store
// read followed by one output load; input is held off meanwhile.
// Throughput: one input item per cycle while receiving, unless a pending output is not yet taken.
// Reset: asynchronous, active low; clears framing state, CRC, error count and max_length
// to 35. The frame store is not cleared, entries are only read after being written.
module escaped_frame_receiver_crc8_core #(
  parameter int unsigned BUFFER_DEPTH = efr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  efr_in_if.sink    rx_i,
  efr_cfg_if.sink   cfg_i,
  efr_out_if.source msg_o
);
  import efr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned LW = $clog2(BUFFER_DEPTH + 1);

  logic [5:0]    max_len_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LENGTH_RST;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_length;
    end
  end

  efr_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW(AW),
    .LW(LW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .msg_o      (msg_o),
    .max_len_i  (max_len_q),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  efr_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW(AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
